FILE: sv/hht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hht_pkg
// Shared types and constants for the hopscotch hash table.
// ----------------------------------------------------------------------------
package hht_pkg;
  localparam int unsigned MaxSlots = 32;
  localparam int unsigned MaxHood  = 8;
  localparam int unsigned SlotW    = $clog2(MaxSlots);
  localparam int unsigned KeyW     = 7;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FAILED  = 2'd2,
    ST_ABSENT  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    TAG_EMPTY   = 2'd0,
    TAG_USED    = 2'd1,
    TAG_DELETED = 2'd2
  } tag_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HOME,
    S_LOOK,
    S_SCAN,
    S_CAND,
    S_CRED,
    S_DONE
  } state_e;

  localparam logic [1:0] CfgTableSize = 2'd0;
  localparam logic [1:0] CfgHood      = 2'd1;
endpackage

FILE: sv/hht_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hht_mod
// Shared modulo step: reduces a small value below n by one compare-subtract.
// The result is only correct for inputs below 2n.
// ----------------------------------------------------------------------------
module hht_mod (
  input  logic [hht_pkg::SlotW+1:0] a_i,
  input  logic [hht_pkg::SlotW:0]   n_i,
  output logic [hht_pkg::SlotW-1:0] r_o
);
  import hht_pkg::*;
  logic [SlotW+1:0] diff;
  always_comb begin
    diff = a_i - {1'b0, n_i};
    if (a_i >= {1'b0, n_i}) begin
      r_o = diff[SlotW-1:0];
    end else begin
      r_o = a_i[SlotW-1:0];
    end
  end
endmodule

FILE: sv/hopscotch_hash_table_top.sv
`timescale 1ns / 1ps
// Hopscotch hash table, keys 0..127 (home = (key%10 + key/10) % size).
// Sequence: lookup/delete reduce the home, then probe up to min(h, size) slots
//   before out_valid_o; insert adds a scan of up to size slots, and each
//   displacement tries up to h-1 candidates, reducing each one's home, and
//   then rescans from the home.
// Throughput: one item at a time; in_stall_o stays high while busy or while
//   a result word waits in the output register.
// Reset: asynchronous, active low; all slots empty, size 32, neighborhood 4.
module hopscotch_hash_table_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] kind_i,
  input  logic [6:0] key_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [4:0] slot_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [0:0] cfg_index_i,
  input  logic [5:0] cfg_data_i
);
  import hht_pkg::*;

  // slot tags live in flops (reset to empty); keys are a plain memory
  // whose contents only matter where the tag is used.
  tag_e             tag_q [MaxSlots];
  logic [KeyW-1:0]  key_q [MaxSlots];

  logic [5:0] size_q;
  logic [3:0] hood_q;

  state_e state_q, state_d;
  logic [1:0]       kind_q;
  logic [KeyW-1:0]  key_in_q;
  logic [SlotW-1:0] home_q;
  logic [SlotW-1:0] idx_q;     // probe pointer
  logic [SlotW:0]   cnt_q;     // steps taken in current walk
  logic [SlotW-1:0] free_q;
  logic [SlotW:0]   iter_q;
  logic [1:0]       st_q;
  logic [SlotW-1:0] at_q;
  logic             ov_q;

  // effective config
  logic [SlotW:0] n_eff;
  logic [3:0]     h_eff;
  always_comb begin
    if (size_q == '0) n_eff = 6'd1;
    else if (size_q > 6'(MaxSlots)) n_eff = (SlotW+1)'(MaxSlots);
    else n_eff = size_q[SlotW:0];
    if (hood_q == '0) h_eff = 4'd1;
    else if (hood_q > 4'(MaxHood)) h_eff = 4'(MaxHood);
    else h_eff = hood_q;
  end

  // key digit sum: key%10 + key/10 via reciprocal multiply (<= 20)
  function automatic logic [4:0] digsum(input logic [KeyW-1:0] k);
    logic [3:0] q;
    logic [KeyW-1:0] r;
    begin
      q = 4'((15'(k) * 15'd205) >> 11);
      r = k - KeyW'(q) * KeyW'(4'd10);
      digsum = 5'(r) + 5'(q);
    end
  endfunction

  // shared modulo unit: mod_a reduced against n by one compare-subtract
  logic [SlotW+1:0] mod_a;
  logic [SlotW-1:0] mod_r;
  hht_mod u_mod (.a_i(mod_a), .n_i(n_eff), .r_o(mod_r));

  // distance from a home to the free slot, via further hht_mod instances
  logic [SlotW-1:0] cur;
  logic [KeyW-1:0]  cur_key;
  tag_e             cur_tag;
  assign cur     = idx_q;
  assign cur_key = key_q[cur];
  assign cur_tag = tag_q[cur];

  // candidate home: digit sum loaded into hred_q, reduced one step a cycle
  logic [SlotW-1:0] cand_home;
  logic [SlotW+1:0] dsum;
  logic [SlotW-1:0] cand_dist;
  logic [SlotW-1:0] free_dist;
  logic [4:0]       hred_q;
  assign cand_home = hred_q[SlotW-1:0];
  assign dsum = {2'b0, free_q} + {1'b0, n_eff} - {2'b0, cand_home};
  hht_mod u_dist (.a_i(dsum), .n_i(n_eff), .r_o(cand_dist));
  logic [SlotW+1:0] fsum;
  assign fsum = {2'b0, cur} + {1'b0, n_eff} - {2'b0, home_q};
  hht_mod u_fd (.a_i(fsum), .n_i(n_eff), .r_o(free_dist));

  // next pointer (idx+1) mod n
  assign mod_a = {2'b0, idx_q} + 1'b1;

  // window start below the free slot just found: (cur + n - (h-1)) % n
  logic [SlotW+1:0] wsum;
  logic [SlotW-1:0] wstart;
  assign wsum = {2'b0, cur} + {1'b0, n_eff} - (SlotW+2)'(h_eff - 1'b1);
  hht_mod u_ws (.a_i(wsum), .n_i(n_eff), .r_o(wstart));

  assign in_stall_o  = (state_q != S_IDLE) || ov_q;
  assign cfg_ready_o = (state_q == S_IDLE) && !ov_q;
  assign out_valid_o = ov_q;
  assign status_o    = st_q;
  assign slot_o      = 5'(at_q);

  logic hit;
  assign hit = (cur_tag == TAG_USED) && (cur_key == key_in_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i && !ov_q) state_d = S_HOME;
      S_HOME: if ({1'b0, hred_q} < n_eff) state_d = S_LOOK;
      S_LOOK: begin
        if (hit) state_d = S_DONE;
        else if (cnt_q + 1'b1 >= (SlotW+1)'(h_eff) || cnt_q + 1'b1 >= n_eff) begin
          if (kind_q == KIND_INSERT) state_d = S_SCAN;
          else state_d = S_DONE;
        end
      end
      S_SCAN: begin
        if (cur_tag != TAG_USED) begin
          if ((SlotW+1)'(free_dist) < (SlotW+1)'(h_eff)) state_d = S_DONE;
          else if (h_eff == 4'd1) state_d = S_DONE;  // no candidate window
          else state_d = S_CAND;
        end else if (cnt_q + 1'b1 >= n_eff) state_d = S_DONE;
      end
      S_CAND: state_d = S_CRED;
      S_CRED: begin
        if ({1'b0, hred_q} < n_eff) begin
          if ((SlotW+1)'(cand_dist) < (SlotW+1)'(h_eff)) begin
            if (iter_q >= (SlotW+1)'(MaxSlots)) state_d = S_DONE;
            else state_d = S_SCAN;
          end else if (cnt_q + 2'd2 >= (SlotW+1)'(h_eff)) state_d = S_DONE;
          else state_d = S_CAND;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      size_q  <= 6'd32;
      hood_q  <= 4'd4;
      ov_q    <= 1'b0;
      st_q    <= ST_DONE;
      at_q    <= '0;
      for (int i = 0; i < MaxSlots; i++) tag_q[i] <= TAG_EMPTY;
    end else begin
      state_q <= state_d;
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgTableSize[0:0]) size_q <= cfg_data_i;
        else hood_q <= cfg_data_i[3:0];
      end
      case (state_q)
        S_IDLE: if (in_valid_i && !ov_q) begin
          kind_q   <= kind_i;
          key_in_q <= key_i;
          hred_q   <= digsum(key_i);
          st_q     <= ST_ABSENT;
          at_q     <= '0;
          iter_q   <= '0;
        end
        S_HOME: begin
          if ({1'b0, hred_q} >= n_eff) hred_q <= hred_q - 5'(n_eff);
          else begin
            home_q <= hred_q[SlotW-1:0];
            idx_q  <= hred_q[SlotW-1:0];
            cnt_q  <= '0;
          end
        end
        S_LOOK: begin
          if (hit) begin
            if (kind_q == KIND_INSERT) st_q <= ST_PRESENT;
            else if (kind_q == KIND_DELETE || kind_q == KIND_LOOKUP) st_q <= ST_DONE;
            else st_q <= ST_ABSENT;
            if (kind_q == KIND_INSERT || kind_q == KIND_DELETE
                || kind_q == KIND_LOOKUP) at_q <= cur;
            if (kind_q == KIND_DELETE) tag_q[cur] <= TAG_DELETED;
          end else if (state_d == S_SCAN) begin
            idx_q <= home_q;
            cnt_q <= '0;
            st_q  <= ST_FAILED;
          end else begin
            idx_q <= mod_r;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_SCAN: begin
          if (cur_tag != TAG_USED) begin
            free_q <= cur;
            if ((SlotW+1)'(free_dist) < (SlotW+1)'(h_eff)) begin
              key_q[cur] <= key_in_q;
              tag_q[cur] <= TAG_USED;
              st_q <= ST_DONE;
              at_q <= cur;
            end else begin
              cnt_q <= '0;
            end
          end else begin
            idx_q <= mod_r;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_CAND: hred_q <= digsum(cur_key);
        S_CRED: begin
          if ({1'b0, hred_q} >= n_eff) begin
            hred_q <= hred_q - 5'(n_eff);
          end else if ((SlotW+1)'(cand_dist) < (SlotW+1)'(h_eff)) begin
            key_q[free_q] <= cur_key;
            tag_q[free_q] <= TAG_USED;
            tag_q[cur]    <= TAG_EMPTY;
            iter_q        <= iter_q + 1'b1;
            idx_q         <= home_q;
            cnt_q         <= '0;
          end else begin
            idx_q <= mod_r;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DONE: ov_q <= 1'b1;
        default: ;
      endcase
      // entering candidate walk: point at window start
      if (state_q == S_SCAN && state_d == S_CAND) idx_q <= wstart;
    end
  end
endmodule

FILE: sv/hht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hht_assert
// Port-level checks for the hopscotch hash table.
// ----------------------------------------------------------------------------
module hht_assert (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic [4:0] slot_o
);
  import hht_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(slot_o))
    else $error("result changed while stalled");

  a_fail_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FAILED || status_o == ST_ABSENT) |-> slot_o == '0)
    else $error("failed result carries a slot");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted a word while busy");
endmodule

bind hopscotch_hash_table_top hht_assert u_hht_assert (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .status_o(status_o),
  .slot_o(slot_o)
);

FILE: tb/hht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hht_checker
// Watches the hash table channels, keeps its own copy of the table, predicts
// each result word and compares it with the block's output.
// ----------------------------------------------------------------------------
module hht_checker
  import hht_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [6:0]  key_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  status_i,
  input  logic [4:0]  slot_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned results_o
);
  typedef struct packed {
    status_e    status;
    logic [4:0] slot;
  } outcome_t;

  outcome_t   outcome_q[$];
  logic [6:0] tbl_key[MaxSlots];
  tag_e       tbl_tag[MaxSlots];
  logic [5:0] size_reg;
  logic [3:0] hood_reg;

  assign pending_o = outcome_q.size();

  function automatic int home_of(int k, int n);
    return ((k % 10) + (k / 10)) % n;
  endfunction

  function automatic bit find_key(int k, int n, int h, output int at);
    int hm;
    int idx;
    hm = home_of(k, n);
    at = 0;
    for (int i = 0; i < h; i++) begin
      idx = (hm + i) % n;
      if (tbl_tag[idx] == TAG_USED && tbl_key[idx] == k) begin
        at = idx;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Insert with displacement; entries moved before a failure stay moved.
  function automatic status_e insert_key(int k, int n, int h, output int at);
    int  hm;
    int  free_at;
    int  cand;
    bit  found;
    bit  moved;
    if (find_key(k, n, h, at)) return ST_PRESENT;
    hm = home_of(k, n);
    for (int it = 0; it <= MaxSlots; it++) begin
      found = 1'b0;
      moved = 1'b0;
      free_at = 0;
      for (int j = 0; j < n; j++) begin
        if (!found && tbl_tag[(hm + j) % n] != TAG_USED) begin
          free_at = (hm + j) % n;
          found = 1'b1;
        end
      end
      if (!found) return ST_FAILED;
      if ((free_at + n - hm) % n < h) begin
        tbl_key[free_at] = k[6:0];
        tbl_tag[free_at] = TAG_USED;
        at = free_at;
        return ST_DONE;
      end
      cand = (free_at + n - (h - 1)) % n;
      for (int j = 0; j + 1 < h; j++) begin
        if (!moved && (free_at + n - home_of(tbl_key[cand], n)) % n < h) begin
          tbl_key[free_at] = tbl_key[cand];
          tbl_tag[free_at] = TAG_USED;
          tbl_tag[cand] = TAG_EMPTY;
          tbl_key[cand] = '0;
          moved = 1'b1;
        end
        if (!moved) cand = (cand + 1) % n;
      end
      if (!moved) return ST_FAILED;
    end
    return ST_FAILED;
  endfunction

  function automatic outcome_t apply_op(logic [1:0] kind, logic [6:0] key);
    int       n;
    int       h;
    int       at;
    status_e  st;
    outcome_t res;
    n = (size_reg == 0) ? 1 : (size_reg > MaxSlots) ? MaxSlots : size_reg;
    h = (hood_reg == 0) ? 1 : (hood_reg > MaxHood) ? MaxHood : hood_reg;
    at = 0;
    case (kind)
      KIND_INSERT: st = insert_key(key, n, h, at);
      KIND_DELETE: begin
        if (find_key(key, n, h, at)) begin
          tbl_tag[at] = TAG_DELETED;
          st = ST_DONE;
        end else begin
          st = ST_ABSENT;
        end
      end
      KIND_LOOKUP: st = find_key(key, n, h, at) ? ST_DONE : ST_ABSENT;
      default: st = ST_ABSENT;
    endcase
    if (st == ST_FAILED || st == ST_ABSENT) at = 0;
    res.status = st;
    res.slot = at[4:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t exp_w;
    if (!rst_ni) begin
      size_reg = 6'd32;
      hood_reg = 4'd4;
      for (int i = 0; i < MaxSlots; i++) begin
        tbl_key[i] = '0;
        tbl_tag[i] = TAG_EMPTY;
      end
      outcome_q.delete();
      fail_cnt_o = 0;
      results_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgTableSize[0:0]) size_reg = cfg_data_i;
        else hood_reg = cfg_data_i[3:0];
      end
      if (in_valid_i && !in_stall_i) outcome_q.push_back(apply_op(kind_i, key_i));
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (outcome_q.size() == 0) begin
          $error("unexpected result word status=%0d slot=%0d", status_i, slot_i);
          fail_cnt_o++;
        end else begin
          exp_w = outcome_q.pop_front();
          if (status_i != exp_w.status) begin
            $error("status: expected %0d, got %0d", exp_w.status, status_i);
            fail_cnt_o++;
          end
          if (slot_i != exp_w.slot) begin
            $error("slot: expected %0d, got %0d", exp_w.slot, slot_i);
            fail_cnt_o++;
          end
        end
      end
    end
  end
endmodule

FILE: tb/hopscotch_hash_table_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hopscotch_hash_table_top_test
// Drives directed and random insert/delete/lookup words through the hash
// table under several size/neighborhood settings; hht_checker does the scoring.
// ----------------------------------------------------------------------------
module hopscotch_hash_table_top_test;
  import hht_pkg::*;

  localparam logic [1:0] KindBad = 2'd3;  // undefined operation
  localparam int PhaseItems = 45;
  localparam int HoldCycles = 300;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] kind_i = '0;
  logic [6:0] key_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic [4:0] slot_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [0:0] cfg_index_i = '0;
  logic [5:0] cfg_data_i = '0;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned results;

  // receiver hold-off request and its own cycle counter
  logic        hold_req = 1'b0;
  int unsigned hold_cnt;
  int unsigned cyc;
  int          burst_left;

  always #1 clk_i = ~clk_i;

  hopscotch_hash_table_top u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .key_i,
    .out_valid_o, .out_stall_i, .status_o, .slot_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  hht_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .kind_i, .key_i,
    .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o), .slot_i(slot_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .results_o(results)
  );

  // Sink: alternating calm and noisy stretches, plus one long hold-off so
  // the output register fills and the block stalls its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_cnt <= 0;
      cyc <= 0;
    end else begin
      cyc <= cyc + 1;
      if (hold_cnt != 0) begin
        out_stall_i <= 1'b1;
        hold_cnt <= hold_cnt - 1;
      end else if (hold_req) begin
        out_stall_i <= 1'b1;
        hold_cnt <= HoldCycles;
      end else if (cyc[6]) begin
        out_stall_i <= ($urandom_range(0, 2) == 0);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [5:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one word and hold it until accepted.
  task automatic send_op(logic [1:0] kind, logic [6:0] key);
    in_valid_i <= 1'b1;
    kind_i <= kind;
    key_i <= key;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Bursty sender: gaps land between bursts of random length.
  task automatic send_bursty(logic [1:0] kind, logic [6:0] key);
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
    send_op(kind, key);
    burst_left--;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [6:0] pick_key();
    // mostly a small pool so keys collide and hit
    if ($urandom_range(0, 9) == 0) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(0, 39));
  endfunction

  function automatic logic [1:0] pick_kind();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return KindBad;
    if (r < 10) return KIND_INSERT;
    if (r < 15) return KIND_DELETE;
    return KIND_LOOKUP;
  endfunction

  logic [5:0] size_set[10] = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd10, 6'd8, 6'd5,
                               6'd16, 6'd32, 6'd3};
  logic [3:0] hood_set[10] = '{4'd4, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd2,
                               4'd4, 4'd8, 4'd15};

  initial begin
    burst_left = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, default setting (size 32, neighborhood 4).
    send_op(KIND_INSERT, 7'd0);
    send_op(KIND_INSERT, 7'd0);     // already present
    send_op(KIND_LOOKUP, 7'd0);
    send_op(KIND_DELETE, 7'd0);
    send_op(KIND_LOOKUP, 7'd0);     // absent after delete
    send_op(KIND_DELETE, 7'd0);     // delete of absent key
    send_op(KindBad, 7'd5);         // undefined operation
    send_op(KIND_INSERT, 7'd127);   // key above 99
    send_op(KIND_LOOKUP, 7'd127);
    // six keys sharing home 5: fills the neighborhood, then the last two fail after a displacement search
    send_op(KIND_INSERT, 7'd5);
    send_op(KIND_INSERT, 7'd14);
    send_op(KIND_INSERT, 7'd23);
    send_op(KIND_INSERT, 7'd32);
    send_op(KIND_INSERT, 7'd41);
    send_op(KIND_INSERT, 7'd50);
    send_op(KIND_DELETE, 7'd14);
    send_op(KIND_INSERT, 7'd41);    // reuses the deleted slot
    send_op(KIND_LOOKUP, 7'd50);
    drain();

    for (int p = 0; p < 10; p++) begin
      write_reg(CfgTableSize[0:0], size_set[p]);
      write_reg(CfgHood[0:0], hood_set[p]);
      if (p == 1) begin
        // full one-slot table: second insert must fail
        send_op(KIND_INSERT, 7'd7);
        send_op(KIND_INSERT, 7'd8);
        send_op(KIND_LOOKUP, 7'd7);
      end
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 3 && i == 10) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          hold_req <= 1'b1;
          @(posedge clk_i);
          hold_req <= 1'b0;
        end
        if (p == 5 && i == 20) begin
          drain();           // sender waits for every result
          burst_left = 0;
        end
        send_bursty(pick_kind(), pick_key());
      end
      drain();
    end

    repeat (50) @(posedge clk_i);
    $display("Covered %0d result words over 10 size/neighborhood settings,", results);
    $display("with displacement, full-table, delete-reuse and undefined-op cases.");
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

FILE: filelist.f
sv/hht_pkg.sv
sv/hht_mod.sv
sv/hopscotch_hash_table_top.sv
sv/hht_checker.sv
tb/hht_checker.sv
tb/hopscotch_hash_table_top_test.sv
